// ===== hw/rtl/ssis_pkg.sv =====
// Package with shared types, codes and constants for the sorted store search unit.
`timescale 1ns / 1ps
`default_nettype none
package ssis_pkg;

  localparam int DefaultDepth = 16;
  localparam int ValueWidth   = 32;
  localparam int LimitWidth   = 5;
  localparam logic [LimitWidth-1:0] ProbeLimitReset = 5'd8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] position;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SR_RDLO,
    S_SR_RDHI,
    S_SR_CHK,
    S_SR_MUL,
    S_SR_DIV,
    S_SR_RDMID,
    S_SR_CMP,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic clear;
    logic rd_lo;
    logic rd_hi;
    logic lat_lo;
    logic lat_hi;
    logic mul;
    logic div_start;
    logic div_step;
    logic rd_mid;
    logic cmp;
    logic set_result;
    logic [2:0] res_status;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic ins_more;
    logic ins_gt;
    logic range_ok;
    logic probes_left;
    logic out_range;
    logic ends_equal;
    logic div_done;
    logic hit;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ssis_ram.sv =====
// Generic RAM with one write port, a separate read port and registered read.
`timescale 1ns / 1ps
`default_nettype none
module ssis_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ssis_datapath.sv =====
// Datapath: table memory, search range registers, multiplier and serial divider.
`timescale 1ns / 1ps
`default_nettype none
module ssis_datapath #(
  parameter int Depth = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ssis_pkg::in_word_t      in_word,
  input  wire logic [4:0]              probe_limit,
  input  wire ssis_pkg::ctrl_t         ctrl,
  output ssis_pkg::stat_t              stat,
  output ssis_pkg::out_word_t          result
);
  import ssis_pkg::*;

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  // Index registers carry two extra bits so that hi can go below zero.
  localparam int IW = AW + 2;
  localparam int QW = 64;
  localparam int DW = 33;

  logic [CW-1:0]         entry_count;
  logic signed [31:0]    key;
  logic [CW-1:0]         ins_p;
  logic signed [IW-1:0]  lo;
  logic signed [IW-1:0]  hi;
  logic signed [IW-1:0]  mid;
  logic [4:0]            probes;
  logic signed [31:0]    vlo;
  logic signed [31:0]    vhi;
  logic [QW-1:0]         quot;
  logic [DW:0]           rem;
  logic [DW-1:0]         den;
  logic [6:0]            div_cnt;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [31:0]           wdata;
  logic [AW-1:0]         raddr;
  logic [31:0]           rdata;
  logic signed [32:0]    key_off;
  logic [AW-1:0]         span;
  logic [DW:0]           rem_shift;
  logic [DW:0]           rem_sub;

  ssis_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Memory address and write selection.
  always_comb begin
    we    = ctrl.ins_shift | ctrl.ins_place;
    waddr = ins_p[AW-1:0];
    wdata = ctrl.ins_shift ? rdata : key;
    raddr = '0;
    if (ctrl.ins_rd) begin
      raddr = AW'(ins_p - CW'(1));
    end else if (ctrl.rd_lo) begin
      raddr = lo[AW-1:0];
    end else if (ctrl.rd_hi) begin
      raddr = hi[AW-1:0];
    end else if (ctrl.rd_mid) begin
      raddr = mid[AW-1:0];
    end
  end

  // The key lies inside [vlo, vhi] when the product is taken, so both factors
  // are non-negative and fit in 32 and AW bits.
  assign key_off   = 33'(key) - 33'(vlo);
  assign span      = AW'(hi - lo);
  assign rem_shift = {rem[DW-1:0], quot[QW-1]};
  assign rem_sub   = rem_shift - {1'b0, den};

  // Status toward the controller.
  always_comb begin
    stat.full        = (entry_count == CW'(Depth));
    stat.ins_more    = (ins_p != '0);
    stat.ins_gt      = ($signed(rdata) > key);
    stat.range_ok    = (lo <= hi);
    stat.probes_left = (probes < probe_limit);
    stat.out_range   = (key < vlo) || (key > vhi);
    stat.ends_equal  = (vlo == vhi);
    stat.div_done    = (div_cnt == '0);
    stat.hit         = ($signed(rdata) == key);
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctrl.clear) begin
      entry_count <= '0;
    end else if (ctrl.ins_place) begin
      entry_count <= entry_count + CW'(1);
    end
    if (ctrl.load) begin
      key    <= in_word.value;
      ins_p  <= entry_count;
      lo     <= '0;
      hi     <= IW'(entry_count) - IW'(1);
      probes <= '0;
    end
    if (ctrl.ins_shift) begin
      ins_p <= ins_p - CW'(1);
    end
    if (ctrl.lat_lo) begin
      vlo <= rdata;
    end
    if (ctrl.lat_hi) begin
      vhi <= rdata;
      mid <= lo;
    end
    // Numerator into the quotient shift register; the divider is restoring.
    if (ctrl.mul) begin
      quot    <= QW'(key_off[31:0]) * QW'(span);
      den     <= DW'(33'(vhi) - 33'(vlo));
      rem     <= '0;
      div_cnt <= 7'(QW);
    end
    if (ctrl.div_step) begin
      div_cnt <= div_cnt - 7'd1;
      if (!rem_sub[DW]) begin
        rem  <= rem_sub;
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        quot <= {quot[QW-2:0], 1'b0};
      end
    end
    if (ctrl.div_start) begin
      mid <= lo + IW'(quot);
    end
    if (ctrl.cmp) begin
      probes <= probes + 5'd1;
      if ($signed(rdata) < key) begin
        lo <= mid + IW'(1);
      end else begin
        hi <= mid - IW'(1);
      end
    end
    if (ctrl.set_result) begin
      result.status <= ctrl.res_status;
      unique case (status_t'(ctrl.res_status))
        ST_INSERTED: result.position <= 4'(ins_p);
        ST_FOUND:    result.position <= 4'(mid);
        default:     result.position <= '0;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ssis_ctrl.sv =====
// Controller state machine sequencing insert, search and clear words.
`timescale 1ns / 1ps
`default_nettype none
module ssis_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ssis_pkg::in_word_t  in_word,
  input  wire ssis_pkg::stat_t     stat,
  output ssis_pkg::ctrl_t          ctrl,
  output logic                     out_valid,
  input  wire logic                out_stall
);
  import ssis_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    ctrl           = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid & out_stall;
    unique case (state)
      S_IDLE: begin
        // A finished word still waiting at the output holds off the next input.
        in_stall = out_valid & out_stall;
        if (in_valid && !in_stall) begin
          ctrl.load = 1'b1;
          state_next = S_DONE;
          unique case (opcode_t'(in_word.opcode))
            OP_INSERT: begin
              if (stat.full) begin
                ctrl.set_result = 1'b1;
                ctrl.res_status = ST_FULL;
              end else begin
                state_next = S_INS_RD;
              end
            end
            OP_SEARCH: state_next = S_SR_CHK;
            OP_CLEAR: begin
              ctrl.clear = 1'b1;
              ctrl.set_result = 1'b1;
              ctrl.res_status = ST_CLEARED;
            end
            default: begin
              ctrl.set_result = 1'b1;
              ctrl.res_status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (stat.ins_more) begin
          ctrl.ins_rd = 1'b1;
          state_next = S_INS_CMP;
        end else begin
          ctrl.ins_place = 1'b1;
          ctrl.set_result = 1'b1;
          ctrl.res_status = ST_INSERTED;
          state_next = S_DONE;
        end
      end
      S_INS_CMP: begin
        if (stat.ins_gt) begin
          ctrl.ins_shift = 1'b1;
          state_next = S_INS_RD;
        end else begin
          ctrl.ins_place = 1'b1;
          ctrl.set_result = 1'b1;
          ctrl.res_status = ST_INSERTED;
          state_next = S_DONE;
        end
      end
      S_SR_CHK: begin
        if (stat.range_ok && stat.probes_left) begin
          ctrl.rd_lo = 1'b1;
          state_next = S_SR_RDLO;
        end else begin
          ctrl.set_result = 1'b1;
          ctrl.res_status = ST_NOT_FOUND;
          state_next = S_DONE;
        end
      end
      S_SR_RDLO: begin
        ctrl.lat_lo = 1'b1;
        ctrl.rd_hi = 1'b1;
        state_next = S_SR_RDHI;
      end
      S_SR_RDHI: begin
        ctrl.lat_hi = 1'b1;
        state_next = S_SR_MUL;
      end
      S_SR_MUL: begin
        if (stat.out_range) begin
          ctrl.set_result = 1'b1;
          ctrl.res_status = ST_NOT_FOUND;
          state_next = S_DONE;
        end else if (stat.ends_equal) begin
          ctrl.rd_mid = 1'b1;
          state_next = S_SR_CMP;
        end else begin
          ctrl.mul = 1'b1;
          state_next = S_SR_DIV;
        end
      end
      S_SR_DIV: begin
        if (stat.div_done) begin
          ctrl.div_start = 1'b1;
          state_next = S_SR_RDMID;
        end else begin
          ctrl.div_step = 1'b1;
        end
      end
      S_SR_RDMID: begin
        ctrl.rd_mid = 1'b1;
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (stat.hit) begin
          ctrl.set_result = 1'b1;
          ctrl.res_status = ST_FOUND;
          state_next = S_DONE;
        end else begin
          ctrl.cmp = 1'b1;
          state_next = S_SR_CHK;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sorted_store_interpolation_search_unit.sv =====
// Each probe is bounded by a 64-step restoring divider; one word in flight at a time.
// A finished word waiting in the result register stalls the input until it is taken.
// Reset (rst, synchronous) empties the table and sets probe_limit to 8.
// Table contents are undefined until written and are never cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_store_interpolation_search_unit #(
  parameter int Depth = ssis_pkg::DefaultDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ssis_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ssis_pkg::out_word_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [4:0]           cfg_data
);
  import ssis_pkg::*;

  ctrl_t      ctrl;
  stat_t      stat;
  logic [4:0] probe_limit;

  // Probe limit register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_limit <= ProbeLimitReset;
    end else if (cfg_valid) begin
      probe_limit <= cfg_data;
    end
  end

  ssis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_data),
    .stat     (stat),
    .ctrl     (ctrl),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  ssis_datapath #(.Depth(Depth)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_word    (in_data),
    .probe_limit(probe_limit),
    .ctrl       (ctrl),
    .stat       (stat),
    .result     (out_data)
  );
endmodule
`default_nettype wire
